### hdl/csem_pkg.sv
// Package for the counting semaphore table: sizes, request and result types,
// and the control structures passed between the sequencer and the count unit.
// No dependencies.
`default_nettype none

package csem_pkg;

  localparam int SLOT_COUNT = 128;
  localparam int COUNT_BITS = 16;
  localparam int ID_BITS    = 16;

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int ADDR_W = SLOT_W + 1;
  localparam int CALC_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
  localparam int CMP_W  = (ID_BITS > 16) ? ID_BITS : 16;

  typedef enum logic [1:0] {
    KIND_CREATE  = 2'd0,
    KIND_DESTROY = 2'd1,
    KIND_WAIT    = 2'd2,
    KIND_SIGNAL  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] initial_value;
    logic [15:0]        sem_id;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] new_id;
    logic        must_sleep;
    logic        wake_one;
  } res_t;

  typedef struct packed {
    kind_e                        kind;
    logic signed [COUNT_BITS-1:0] count;
    logic signed [15:0]           initial_value;
  } alu_req_t;

  typedef struct packed {
    logic signed [COUNT_BITS-1:0] count;
    logic                         must_sleep;
    logic                         wake_one;
  } alu_rsp_t;

endpackage

`default_nettype wire

### hdl/csem_alu.sv
// Saturating count unit: loads an initial count or steps a count by one,
// and judges the sleep and wake flags on the stored result. Uses csem_pkg.
`default_nettype none

module csem_alu (
  input  csem_pkg::alu_req_t req_i,
  output csem_pkg::alu_rsp_t rsp_o
);

  localparam int CW = csem_pkg::CALC_W;
  localparam int NB = csem_pkg::COUNT_BITS;

  localparam logic signed [CW-1:0] CntMax = {{(CW-NB+1){1'b0}}, {(NB-1){1'b1}}};
  localparam logic signed [CW-1:0] CntMin = {{(CW-NB+1){1'b1}}, {(NB-1){1'b0}}};
  localparam logic signed [CW-1:0] StepDown = CW'(-1);
  localparam logic signed [CW-1:0] StepUp = CW'(1);

  logic signed [CW-1:0] opa;
  logic signed [CW-1:0] delta;
  logic signed [CW-1:0] sum;
  logic signed [NB-1:0] sat;

  always_comb begin
    if (req_i.kind == csem_pkg::KIND_CREATE) begin
      opa = CW'(req_i.initial_value);
    end else begin
      opa = CW'(req_i.count);
    end
    case (req_i.kind)
      csem_pkg::KIND_WAIT:   delta = StepDown;
      csem_pkg::KIND_SIGNAL: delta = StepUp;
      default:               delta = '0;
    endcase
    sum = opa + delta;
    if (sum > CntMax) begin
      sat = NB'(CntMax);
    end else if (sum < CntMin) begin
      sat = NB'(CntMin);
    end else begin
      sat = NB'(sum);
    end
    rsp_o.count      = sat;
    rsp_o.must_sleep = (req_i.kind == csem_pkg::KIND_WAIT) && sat[NB-1];
    rsp_o.wake_one   = (req_i.kind == csem_pkg::KIND_SIGNAL) &&
                       (sat[NB-1] || (sat == '0));
  end

endmodule

`default_nettype wire

### hdl/csem_scan.sv
// Slot table sequencer: holds the used map, the count and identifier memories
// and the identifier counter, scans one slot a cycle and applies the request.
// Uses csem_pkg and csem_alu.
`default_nettype none

module csem_scan (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 req_valid_i,
  output logic                req_ready_o,
  input  csem_pkg::req_t      req_i,
  output logic                res_valid_o,
  input  wire                 res_ready_i,
  output csem_pkg::res_t      res_o
);

  localparam int N  = csem_pkg::SLOT_COUNT;
  localparam int SW = csem_pkg::SLOT_W;
  localparam int AW = csem_pkg::ADDR_W;
  localparam int NB = csem_pkg::COUNT_BITS;
  localparam int IB = csem_pkg::ID_BITS;
  localparam int CM = csem_pkg::CMP_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  state_e               state_q, state_d;
  csem_pkg::req_t       req_q;
  logic [AW-1:0]        addr_q, addr_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [SW-1:0]        rd_idx_q, rd_idx_d;
  logic signed [NB-1:0] rd_count_q;
  logic [IB-1:0]        rd_ident_q;
  logic                 hit_q, hit_d;
  logic [SW-1:0]        hit_idx_q, hit_idx_d;
  logic signed [NB-1:0] hit_count_q, hit_count_d;
  logic [N-1:0]         used_q, used_d;
  logic [IB-1:0]        id_cnt_q, id_cnt_d;

  logic signed [NB-1:0] mem_count_q [N];
  logic [IB-1:0]        mem_ident_q [N];

  logic                 issue;
  logic                 match;
  logic                 cnt_we;
  logic                 id_we;
  logic                 is_create;
  csem_pkg::alu_req_t   alu_req;
  csem_pkg::alu_rsp_t   alu_rsp;

  assign is_create   = (req_q.kind == csem_pkg::KIND_CREATE);
  assign req_ready_o = (state_q == S_IDLE);
  assign issue       = (addr_q < AW'(N));

  always_comb begin
    if (is_create) begin
      match = !used_q[rd_idx_q];
    end else begin
      match = used_q[rd_idx_q] && (CM'(rd_ident_q) == CM'(req_q.sem_id));
    end
  end

  assign alu_req.kind          = req_q.kind;
  assign alu_req.count         = hit_count_q;
  assign alu_req.initial_value = req_q.initial_value;

  csem_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_count_d = hit_count_q;
    used_d      = used_q;
    id_cnt_d    = id_cnt_q;
    cnt_we      = 1'b0;
    id_we       = 1'b0;
    res_valid_o = 1'b0;

    res_o.status     = csem_pkg::ST_OK;
    res_o.new_id     = '0;
    res_o.must_sleep = 1'b0;
    res_o.wake_one   = 1'b0;
    if (!hit_q) begin
      res_o.status = is_create ? csem_pkg::ST_FULL : csem_pkg::ST_NOT_FOUND;
    end else begin
      if (is_create) begin
        res_o.new_id = 16'(id_cnt_q);
      end
      res_o.must_sleep = alu_rsp.must_sleep;
      res_o.wake_one   = alu_rsp.wake_one;
    end

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          state_d = S_SCAN;
          addr_d  = '0;
        end
      end
      S_SCAN: begin
        if (issue) begin
          rd_vld_d = 1'b1;
          rd_idx_d = addr_q[SW-1:0];
          addr_d   = addr_q + AW'(1);
        end
        if (rd_vld_q) begin
          if (match) begin
            hit_d       = 1'b1;
            hit_idx_d   = rd_idx_q;
            hit_count_d = rd_count_q;
            state_d     = S_EXEC;
            rd_vld_d    = 1'b0;
          end else if (rd_idx_q == SW'(N - 1)) begin
            hit_d    = 1'b0;
            state_d  = S_EXEC;
            rd_vld_d = 1'b0;
          end
        end
      end
      S_EXEC: begin
        if (res_ready_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
          hit_d       = 1'b0;
          if (hit_q) begin
            case (req_q.kind)
              csem_pkg::KIND_CREATE: begin
                used_d[hit_idx_q] = 1'b1;
                cnt_we            = 1'b1;
                id_we             = 1'b1;
                id_cnt_d          = id_cnt_q + IB'(1);
              end
              csem_pkg::KIND_DESTROY: begin
                used_d[hit_idx_q] = 1'b0;
              end
              default: begin
                cnt_we = 1'b1;
              end
            endcase
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      hit_count_q <= '0;
      used_q      <= '0;
      id_cnt_q    <= '0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      rd_vld_q    <= rd_vld_d;
      rd_idx_q    <= rd_idx_d;
      hit_q       <= hit_d;
      hit_idx_q   <= hit_idx_d;
      hit_count_q <= hit_count_d;
      used_q      <= used_d;
      id_cnt_q    <= id_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      mem_count_q[hit_idx_q] <= alu_rsp.count;
    end
    if (id_we) begin
      mem_ident_q[hit_idx_q] <= id_cnt_q;
    end
    rd_count_q <= mem_count_q[addr_q[SW-1:0]];
    rd_ident_q <= mem_ident_q[addr_q[SW-1:0]];
  end

  // A slot found for create must be free; one found by identifier must be in use.
  a_create_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && hit_q && is_create) |-> !used_q[hit_idx_q])
    else $error("create selected a slot that is already in use");

  a_lookup_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && hit_q && !is_create) |-> used_q[hit_idx_q])
    else $error("lookup selected a slot that is not in use");

  a_res_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (state_q == S_IDLE) && !hit_q)
    else $error("sequencer did not return to idle after a result");

  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> (state_q == S_SCAN) && (addr_q == '0) && !rd_vld_q)
    else $error("scan did not start from the first slot");

  a_full_exhausted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && !hit_q && is_create) |-> (used_q == '1))
    else $error("create reported a full table while a slot was free");

endmodule

`default_nettype wire

### hdl/counting_semaphore_table_unit.sv
// Flow: an accepted request scans from slot 0 up to its match; a full table or an
// unknown identifier scans every slot. The result then goes to the m_axis register.
// Throughput: one transaction at a time, set by the slot scan that reads one
// memory entry a cycle; a new request is taken the cycle after the result is
// registered, even if that result is still waiting on m_axis_tready_i.
// Reset clears the used map and identifier counter at once; no clearing pass.
`default_nettype none

module counting_semaphore_table_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [31:0] s_axis_tdata_i,  // initial_value[15:0], sem_id[31:16]
  input  wire  [1:0]  s_axis_tuser_i,  // kind[1:0]
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o   // status[1:0], new_id[17:2],
                                       // must_sleep[18], wake_one[19], zero[23:20]
);

  csem_pkg::req_t req;
  csem_pkg::res_t res;
  csem_pkg::res_t out_q;
  logic           out_vld_q;
  logic           res_valid;
  logic           res_ready;

  assign req.kind          = csem_pkg::kind_e'(s_axis_tuser_i);
  assign req.initial_value = s_axis_tdata_i[15:0];
  assign req.sem_id        = s_axis_tdata_i[31:16];

  assign res_ready = !out_vld_q || m_axis_tready_i;

  csem_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'b0000, out_q.wake_one, out_q.must_sleep,
                            out_q.new_id, out_q.status};

endmodule

`default_nettype wire

### sim/counting_semaphore_table_unit_tb.sv
// Self-checking testbench for counting_semaphore_table_unit: requests are driven as stream
// transactions and every result is checked against a behavioural semaphore table model.
// Depends on csem_pkg and the counting_semaphore_table_unit RTL.
module counting_semaphore_table_unit_tb;
  import csem_pkg::*;

  localparam longint COUNT_HI = (longint'(1) << (COUNT_BITS - 1)) - 1;
  localparam longint COUNT_LO = -COUNT_HI - 1;
  localparam int SETTLE_CYCLES = SLOT_COUNT + 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  bit                           sem_used [SLOT_COUNT];
  logic signed [COUNT_BITS-1:0] sem_count [SLOT_COUNT];
  logic [ID_BITS-1:0]           sem_ident [SLOT_COUNT];
  logic [ID_BITS-1:0]           ident_counter = '0;

  req_t pending_requests[$];
  res_t expected_replies[$];
  int   mismatch_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   holdoff_left = 0;
  bit   req_taken = 1'b0;

  counting_semaphore_table_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic req_t make_req(kind_e k, logic signed [15:0] v, logic [15:0] id);
    req_t rq;
    rq.kind = k;
    rq.initial_value = v;
    rq.sem_id = id;
    return rq;
  endfunction

  function automatic logic signed [COUNT_BITS-1:0] clamp_count(longint v);
    longint c;
    c = (v > COUNT_HI) ? COUNT_HI : ((v < COUNT_LO) ? COUNT_LO : v);
    return c[COUNT_BITS-1:0];
  endfunction

  // Lowest used slot holding the identifier, or -1.
  function automatic int find_slot(logic [15:0] id);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (sem_used[i] && longint'(sem_ident[i]) == longint'(id)) return i;
    end
    return -1;
  endfunction

  function automatic res_t execute_request(req_t rq);
    res_t r;
    int   slot;
    r.status = ST_OK;
    r.new_id = '0;
    r.must_sleep = 1'b0;
    r.wake_one = 1'b0;
    slot = -1;
    if (rq.kind == KIND_CREATE) begin
      for (int i = 0; i < SLOT_COUNT && slot < 0; i++) begin
        if (!sem_used[i]) slot = i;
      end
      if (slot < 0) begin
        r.status = ST_FULL;
      end else begin
        sem_used[slot] = 1'b1;
        sem_count[slot] = clamp_count(longint'(rq.initial_value));
        sem_ident[slot] = ident_counter;
        r.new_id = 16'(ident_counter);
        ident_counter = ident_counter + 1'b1;
      end
    end else begin
      slot = find_slot(rq.sem_id);
      if (slot < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        case (rq.kind)
          KIND_DESTROY: begin
            sem_used[slot] = 1'b0;
          end
          KIND_WAIT: begin
            sem_count[slot] = clamp_count(longint'(sem_count[slot]) - 1);
            r.must_sleep = sem_count[slot] < 0;
          end
          default: begin
            sem_count[slot] = clamp_count(longint'(sem_count[slot]) + 1);
            r.wake_one = sem_count[slot] <= 0;
          end
        endcase
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] live_ident();
    int start;
    int n;
    start = $urandom_range(SLOT_COUNT - 1);
    for (int k = 0; k < SLOT_COUNT; k++) begin
      n = (start + k) % SLOT_COUNT;
      if (sem_used[n]) return 16'(sem_ident[n]);
    end
    return 16'($urandom);
  endfunction

  function automatic logic signed [15:0] pick_initial();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(3));
      3: return 16'hffff - 16'($urandom_range(2));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic req_t random_request();
    int   roll;
    kind_e k;
    roll = $urandom_range(99);
    if (roll < 25) k = KIND_CREATE;
    else if (roll < 40) k = KIND_DESTROY;
    else if (roll < 70) k = KIND_WAIT;
    else k = KIND_SIGNAL;
    return make_req(k, pick_initial(),
                    ($urandom_range(99) < 85) ? live_ident() : 16'($urandom));
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic offer(req_t rq);
    while (pending_requests.size() >= 2) @(posedge clk_i);
    pending_requests.push_back(rq);
  endtask

  task automatic settle();
    while (pending_requests.size() != 0 || s_tvalid || expected_replies.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic run_random(int send_pct, int recv_pct, int n);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n) begin
      if ($urandom_range(99) < 2) settle();
      offer(random_request());
    end
    settle();
  endtask

  always @(negedge clk_i) begin : request_driver
    req_t rq;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      req_taken = 1'b0;
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        rq = pending_requests.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {rq.sem_id, rq.initial_value};
        s_tuser <= rq.kind;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    m_tready <= rst_ni && holdoff_left == 0 && $urandom_range(99) >= recv_stall_pct;
  end

  always @(posedge clk_i) begin
    if (holdoff_left > 0) holdoff_left <= holdoff_left - 1;
  end

  always @(posedge clk_i) begin : reply_monitor
    res_t want;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        expected_replies.push_back(execute_request(
          make_req(kind_e'(s_tuser), s_tdata[15:0], s_tdata[31:16])));
        req_taken = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        if (expected_replies.size() == 0) begin
          $error("result transaction with no request outstanding: tdata %h", m_tdata);
          mismatch_count++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", 16'(want.status), 16'(m_tdata[1:0]));
          check_field("new_id", want.new_id, m_tdata[17:2]);
          check_field("must_sleep", 16'(want.must_sleep), 16'(m_tdata[18]));
          check_field("wake_one", 16'(want.wake_one), 16'(m_tdata[19]));
        end
      end
    end
  end

  initial begin
    #12000000;
    $display("counting_semaphore_table_unit_tb failed");
    $finish;
  end

  initial begin
    int                 free_slots;
    logic [ID_BITS-1:0] fresh_ident;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, extreme counts, saturation, both flags, slot reuse.
    offer(make_req(KIND_WAIT,    16'sd0,     16'd5));
    offer(make_req(KIND_SIGNAL,  16'sd0,     16'd0));
    offer(make_req(KIND_DESTROY, 16'sd0,     16'd0));
    offer(make_req(KIND_CREATE,  16'sh7fff,  16'hffff));
    offer(make_req(KIND_CREATE,  16'sh8000,  16'd0));
    offer(make_req(KIND_CREATE,  16'sd0,     16'd0));
    offer(make_req(KIND_CREATE,  -16'sd1,    16'd0));
    offer(make_req(KIND_SIGNAL,  16'sd0,     16'd0));
    offer(make_req(KIND_WAIT,    16'sd0,     16'd1));
    offer(make_req(KIND_WAIT,    16'sd0,     16'd2));
    offer(make_req(KIND_SIGNAL,  16'sd0,     16'd2));
    offer(make_req(KIND_SIGNAL,  16'sd0,     16'd3));
    offer(make_req(KIND_WAIT,    16'sd0,     16'd3));
    offer(make_req(KIND_SIGNAL,  16'sd0,     16'd1));
    offer(make_req(KIND_DESTROY, 16'sd0,     16'd1));
    offer(make_req(KIND_CREATE,  16'sd1,     16'd0));
    offer(make_req(KIND_WAIT,    16'sd0,     16'd4));
    offer(make_req(KIND_DESTROY, 16'sd0,     16'hffff));
    offer(make_req(KIND_WAIT,    16'sd0,     16'd0));
    offer(make_req(KIND_SIGNAL,  -16'sd1,    16'd4));
    offer(make_req(KIND_DESTROY, 16'sd0,     16'd0));
    offer(make_req(KIND_DESTROY, 16'sd0,     16'd2));
    offer(make_req(KIND_DESTROY, 16'sd0,     16'd3));
    offer(make_req(KIND_DESTROY, 16'sd0,     16'd4));
    settle();

    run_random(0, 0, 80);
    run_random(58, 0, 80);
    run_random(0, 58, 80);
    run_random(38, 38, 80);

    // The result side holds off for a long stretch while requests keep coming.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(negedge clk_i);
    holdoff_left = 300;
    repeat (12) offer(random_request());
    settle();

    // Fill the table, overrun it, then churn it starting from a full table.
    free_slots = 0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!sem_used[i]) free_slots++;
    end
    send_idle_pct = 20;
    recv_stall_pct = 20;
    repeat (free_slots + 3) offer(make_req(KIND_CREATE, pick_initial(), 16'($urandom)));
    run_random(20, 20, 40);

    // Empty the table, then take a fresh semaphore through its whole life.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (sem_used[i]) offer(make_req(KIND_DESTROY, 16'sd0, 16'(sem_ident[i])));
    end
    settle();
    fresh_ident = ident_counter;
    offer(make_req(KIND_CREATE,  -16'sd1, 16'd0));
    offer(make_req(KIND_WAIT,    16'sd0,  16'(fresh_ident)));
    offer(make_req(KIND_SIGNAL,  16'sd0,  16'(fresh_ident)));
    offer(make_req(KIND_DESTROY, 16'sd0,  16'(fresh_ident)));
    offer(make_req(KIND_WAIT,    16'sd0,  16'(fresh_ident)));
    offer(make_req(KIND_DESTROY, 16'sd0,  16'(fresh_ident)));
    offer(make_req(KIND_SIGNAL,  16'sd0,  16'(fresh_ident)));
    settle();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("counting_semaphore_table_unit_tb passed");
    end else begin
      $display("counting_semaphore_table_unit_tb failed");
    end
    $finish;
  end

endmodule
